// File: design/tpr_pkg.sv
// turtle plotter package: word types, command and heading codes, state encoding
`timescale 1ns / 1ps
`default_nettype none

package tpr_pkg;

   // field widths fixed by the word formats
   localparam int MODE_W   = 3;
   localparam int DIST_W   = 5;
   localparam int INDEX_W  = 5;
   localparam int CELLS_W  = 20;

   // command codes
   localparam logic [MODE_W-1:0] MODE_PEN_UP     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PEN_DOWN   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TURN_RIGHT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TURN_LEFT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MOVE       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd5;

   // heading codes, turning right steps up by one
   localparam logic [1:0] HEAD_EAST  = 2'd0;
   localparam logic [1:0] HEAD_SOUTH = 2'd1;
   localparam logic [1:0] HEAD_WEST  = 2'd2;
   localparam logic [1:0] HEAD_NORTH = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DIST_W-1:0] distance;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] row_index;
      logic [CELLS_W-1:0] row_cells;
      logic               last_row;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_DUMP
   } state_type;

endpackage

`default_nettype wire

// File: design/tpr_ram.sv
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tpr_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 20
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port, read data holds when not read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/turtle_pen_raster.sv
// turtle plotter: bitmap rows in a memory, read-modify-write per touched row, row dump
// pen, turn and pen-up move words are done when taken; a move with the pen down
// rewrites one row along a row and distance rows down a column, one row read per cycle
// through one port; a dump reads row 0 up to the last row into the output register,
// one row per cycle while the result side keeps up
// reset clears position, heading, pen and per-row valid flags, unwritten rows read blank
`timescale 1ns / 1ps
`default_nettype none

module turtle_pen_raster #(
   parameter int GRID_SIZE = 20
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire tpr_pkg::req_type req_word,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output tpr_pkg::rsp_type     rsp_word
);

   localparam int PW   = $clog2(GRID_SIZE);
   localparam int PADW = (GRID_SIZE > tpr_pkg::CELLS_W) ? GRID_SIZE : tpr_pkg::CELLS_W;
   localparam logic [PW-1:0] LAST_POS = PW'(GRID_SIZE - 1);

   // control state
   tpr_pkg::state_type state_ff, state_in;
   logic [PW-1:0]        pos_row_ff, pos_row_in;
   logic [PW-1:0]        pos_col_ff, pos_col_in;
   logic [1:0]           heading_ff, heading_in;
   logic                 pen_ff, pen_in;
   logic [PW-1:0]        addr_ff, addr_in;
   logic [PW-1:0]        steps_ff, steps_in;
   logic                 step_down_ff, step_down_in;
   logic [GRID_SIZE-1:0] mask_ff, mask_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [PW-1:0]        rd_addr_ff;
   logic                 rd_ok_ff;
   logic [GRID_SIZE-1:0] row_ok_ff;
   logic                 out_valid_ff, out_valid_in;
   tpr_pkg::rsp_type     out_ff, out_in;

   // memory port signals
   logic                 rd_en;
   logic [PW-1:0]        rd_addr;
   logic                 wr_en;
   logic [GRID_SIZE-1:0] wr_data;
   logic [GRID_SIZE-1:0] rd_data;
   logic [GRID_SIZE-1:0] rd_row;

   // move setup
   logic                 req_take;
   logic [PW-1:0]        room;
   logic [tpr_pkg::DIST_W-1:0] dist_clip;
   logic [PW-1:0]        dist_pw;
   logic [PW-1:0]        span_lo;
   logic [PW-1:0]        span_hi;
   logic [GRID_SIZE-1:0] row_mask;
   logic [GRID_SIZE-1:0] col_mask;
   logic                 load_out;
   logic [PADW-1:0]      cells_pad;

   tpr_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != tpr_pkg::ST_IDLE) || rd_pend_ff;
   assign req_take  = req_valid && !req_stall;
   assign load_out  = rd_pend_ff && (!out_valid_ff || !rsp_stall);

   // row read back, blank until first written
   assign rd_row  = rd_ok_ff ? rd_data : '0;
   assign wr_data = rd_row | mask_ff;

   // room to the edge and clipped distance
   always_comb begin
      case (heading_ff)
         tpr_pkg::HEAD_EAST:  room = LAST_POS - pos_col_ff;
         tpr_pkg::HEAD_SOUTH: room = LAST_POS - pos_row_ff;
         tpr_pkg::HEAD_WEST:  room = pos_col_ff;
         default:             room = pos_row_ff;
      endcase
      if (req_word.distance > tpr_pkg::DIST_W'(room)) begin
         dist_clip = tpr_pkg::DIST_W'(room);
      end else begin
         dist_clip = req_word.distance;
      end
      dist_pw = PW'(dist_clip);
   end

   // cell masks for a move along a row and down a column
   always_comb begin
      if (heading_ff == tpr_pkg::HEAD_EAST) begin
         span_lo = pos_col_ff + PW'(1);
         span_hi = pos_col_ff + dist_pw;
      end else begin
         span_lo = pos_col_ff - dist_pw;
         span_hi = pos_col_ff - PW'(1);
      end
      for (int j = 0; j < GRID_SIZE; j++) begin
         row_mask[j] = (j >= int'(span_lo)) && (j <= int'(span_hi));
         col_mask[j] = (j == int'(pos_col_ff));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_word.mode == tpr_pkg::MODE_DUMP) begin
                  state_in = tpr_pkg::ST_DUMP;
               end else if (req_word.mode == tpr_pkg::MODE_MOVE && pen_ff
                            && dist_clip != '0) begin
                  state_in = tpr_pkg::ST_MOVE;
               end
            end
         end
         tpr_pkg::ST_MOVE: begin
            if (steps_ff == '0 && !wr_pend_ff) begin
               state_in = tpr_pkg::ST_IDLE;
            end
         end
         tpr_pkg::ST_DUMP: begin
            if ((!rd_pend_ff || load_out) && addr_ff == LAST_POS) begin
               state_in = tpr_pkg::ST_IDLE;
            end
         end
         default: state_in = tpr_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      pos_row_in   = pos_row_ff;
      pos_col_in   = pos_col_ff;
      heading_in   = heading_ff;
      pen_in       = pen_ff;
      addr_in      = addr_ff;
      steps_in     = steps_ff;
      step_down_in = step_down_ff;
      mask_in      = mask_ff;
      wr_pend_in   = 1'b0;
      rd_pend_in   = rd_pend_ff && !load_out;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      case (state_ff)
         tpr_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_word.mode)
                  tpr_pkg::MODE_PEN_UP:     pen_in = 1'b0;
                  tpr_pkg::MODE_PEN_DOWN:   pen_in = 1'b1;
                  tpr_pkg::MODE_TURN_RIGHT: heading_in = heading_ff + 2'd1;
                  tpr_pkg::MODE_TURN_LEFT:  heading_in = heading_ff - 2'd1;
                  tpr_pkg::MODE_MOVE: begin
                     case (heading_ff)
                        tpr_pkg::HEAD_EAST: begin
                           pos_col_in = pos_col_ff + dist_pw;
                           addr_in    = pos_row_ff;
                           steps_in   = PW'(1);
                           mask_in    = row_mask;
                        end
                        tpr_pkg::HEAD_WEST: begin
                           pos_col_in = pos_col_ff - dist_pw;
                           addr_in    = pos_row_ff;
                           steps_in   = PW'(1);
                           mask_in    = row_mask;
                        end
                        tpr_pkg::HEAD_SOUTH: begin
                           pos_row_in   = pos_row_ff + dist_pw;
                           addr_in      = pos_row_ff + PW'(1);
                           steps_in     = dist_pw;
                           step_down_in = 1'b1;
                           mask_in      = col_mask;
                        end
                        default: begin
                           pos_row_in   = pos_row_ff - dist_pw;
                           addr_in      = pos_row_ff - PW'(1);
                           steps_in     = dist_pw;
                           step_down_in = 1'b0;
                           mask_in      = col_mask;
                        end
                     endcase
                  end
                  tpr_pkg::MODE_DUMP: addr_in = '0;
                  default: ;
               endcase
            end
         end
         tpr_pkg::ST_MOVE: begin
            // read the next row while the previous one is written back
            if (steps_ff != '0) begin
               rd_en      = 1'b1;
               wr_pend_in = 1'b1;
               steps_in   = steps_ff - PW'(1);
               addr_in    = step_down_ff ? addr_ff + PW'(1) : addr_ff - PW'(1);
            end
            wr_en = wr_pend_ff;
         end
         tpr_pkg::ST_DUMP: begin
            if (!rd_pend_ff || load_out) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               addr_in    = addr_ff + PW'(1);
            end
         end
         default: ;
      endcase
      // output register takes the held row
      if (load_out) begin
         out_valid_in       = 1'b1;
         out_in.row_index   = tpr_pkg::INDEX_W'(rd_addr_ff);
         out_in.row_cells   = cells_pad[tpr_pkg::CELLS_W-1:0];
         out_in.last_row    = (rd_addr_ff == LAST_POS);
      end
   end

   assign cells_pad = PADW'(rd_row);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpr_pkg::ST_IDLE;
         pos_row_ff   <= '0;
         pos_col_ff   <= '0;
         heading_ff   <= tpr_pkg::HEAD_EAST;
         pen_ff       <= 1'b0;
         steps_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         row_ok_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         heading_ff   <= heading_in;
         pen_ff       <= pen_in;
         steps_ff     <= steps_in;
         wr_pend_ff   <= wr_pend_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            row_ok_ff[rd_addr_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      step_down_ff <= step_down_in;
      mask_ff      <= mask_in;
      out_ff       <= out_in;
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
         rd_ok_ff   <= row_ok_ff[rd_addr];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   // the position never leaves the grid
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (int'(pos_row_ff) < GRID_SIZE) && (int'(pos_col_ff) < GRID_SIZE))
      else $error("turtle position outside the grid");

   // a write-back never hits the row being read in the same cycle
   a_no_row_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != rd_addr_ff))
      else $error("read and write of the same row in one cycle");

   // no row is written while a dump walks the memory
   a_dump_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpr_pkg::ST_DUMP) |-> !wr_en)
      else $error("row write during a dump");

   // a held row is not overwritten by a new read
   a_hold_row: assert property (@(posedge clock) disable iff (reset)
      (rd_pend_ff && !load_out) |-> !rd_en)
      else $error("pending dump row overwritten");

endmodule

`default_nettype wire
